[rtl/core/sorted_median_of_set_unit_macros.svh]
// assertion macros for the sorted median unit
`ifndef SORTED_MEDIAN_OF_SET_UNIT_MACROS_SVH
`define SORTED_MEDIAN_OF_SET_UNIT_MACROS_SVH

`ifndef SYNTH
`define SMOS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SMOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SMOS_ASSERT_IMPL(label, ante, cons)
`define SMOS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/core/smos_pkg.sv]
// shared constants and status codes for the sorted median unit
`timescale 1ns / 1ps
package smos_pkg;
    localparam int MAX_ITEMS  = 64;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int VALUE_W    = 32;
    localparam int MED_W      = 33;
    localparam int ICNT_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int OUT_BITS   = MED_W + ICNT_W + STATUS_W;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int S_TDATA_W  = ((VALUE_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
endpackage

[rtl/core/sorted_median_of_set_unit.sv]
// sorted median unit: insertion sort into a ram and doubled median of each set
// usage:
//   s_ channel carries one signed 32-bit value per transaction in s_tdata;
//   s_tlast closes the set, and its value belongs to the set too.
//   m_ channel carries one result per closed set: doubled median, count
//   of kept values and status (ok, empty, overflow).
//   up to MAX_ITEMS values are kept; later values in the set are dropped
//   and the result reports overflow.
// timing:
//   a value is inserted by one shared compare walking down the sorted ram:
//   it is accepted in S_IDLE, then each stored value it is compared with costs
//   one ram read (S_READ) and one compare and shift (S_CMP), plus S_PUT if it lands first.
//   a value into a full or empty store is handled in S_IDLE alone.
//   closing a set runs states S_MEDA to S_MEDD for two ram reads and the shared adder.
//   s_tready is high only while the sequencer idles.
// reset and stall:
//   aresetn empties the set and clears the result valid flag.
//   a stalled result holds in the output register; the next set can load
//   meanwhile, and only the next result waits for the register to free.
`timescale 1ns / 1ps
`include "sorted_median_of_set_unit_macros.svh"
module sorted_median_of_set_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [smos_pkg::S_TDATA_W-1:0] s_tdata,  // value[31:0]
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // median_twice[32:0], item_count[39:33], status[41:40], zero pad
    output logic [smos_pkg::M_TDATA_W-1:0] m_tdata
);
    import smos_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_MEDA = 3'd4;
    localparam logic [2:0] S_MEDB = 3'd5;
    localparam logic [2:0] S_MEDC = 3'd6;
    localparam logic [2:0] S_MEDD = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic                 ovf_reg, ovf_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic [ADDR_W-1:0]    rd_addr_reg, rd_addr_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic                 last_reg, last_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [VALUE_W-1:0]   wr_data;
    logic [VALUE_W-1:0]   rd_data;

    logic                 s_acc;
    logic                 out_free;
    logic                 greater;
    logic [MED_W-1:0]     sum;
    logic [STATUS_W-1:0]  status;
    logic [CNT_W-1:0]     mid;

    smos_ram #(
        .DEPTH(MAX_ITEMS),
        .WIDTH(VALUE_W)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr_reg),
        .rd_data(rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // shared compare and adder
    assign greater = $signed(rd_data) > $signed(value_reg);
    assign sum     = {acc_reg[VALUE_W-1], acc_reg}
                   + (fill_reg[0] ? {acc_reg[VALUE_W-1], acc_reg}
                                  : {rd_data[VALUE_W-1], rd_data});
    assign mid     = fill_reg >> 1;

    always_comb begin
        priority if (fill_reg == '0) begin
            status = ST_EMPTY;
        end else if (ovf_reg) begin
            status = ST_OVERFLOW;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        rd_addr_next  = rd_addr_reg;
        value_next    = value_reg;
        last_next     = last_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = value_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    value_next = s_tdata[VALUE_W-1:0];
                    last_next  = s_tlast;
                    priority if (fill_reg == CNT_W'(MAX_ITEMS)) begin
                        ovf_next   = 1'b1;
                        state_next = s_tlast ? S_MEDA : S_IDLE;
                    end else if (fill_reg == '0) begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = s_tdata[VALUE_W-1:0];
                        fill_next  = CNT_W'(1);
                        state_next = s_tlast ? S_MEDA : S_IDLE;
                    end else begin
                        pos_next     = ADDR_W'(fill_reg);
                        rd_addr_next = ADDR_W'(fill_reg - CNT_W'(1));
                        state_next   = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                wr_en = 1'b1;
                if (greater) begin
                    wr_data = rd_data;
                    pos_next = pos_reg - ADDR_W'(1);
                    if (pos_reg == ADDR_W'(1)) begin
                        state_next = S_PUT;
                    end else begin
                        rd_addr_next = pos_reg - ADDR_W'(2);
                        state_next   = S_READ;
                    end
                end else begin
                    fill_next  = fill_reg + CNT_W'(1);
                    state_next = last_reg ? S_MEDA : S_IDLE;
                end
            end
            S_PUT: begin
                wr_en      = 1'b1;
                fill_next  = fill_reg + CNT_W'(1);
                state_next = last_reg ? S_MEDA : S_IDLE;
            end
            S_MEDA: begin
                rd_addr_next = ADDR_W'(mid);
                state_next   = S_MEDB;
            end
            S_MEDB: begin
                rd_addr_next = ADDR_W'(mid - CNT_W'(1));
                state_next   = S_MEDC;
            end
            S_MEDC: begin
                acc_next   = rd_data;
                state_next = S_MEDD;
            end
            S_MEDD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({status, ICNT_W'(fill_reg),
                                    (fill_reg == '0) ? MED_W'(0) : sum});
                    fill_next     = '0;
                    ovf_next      = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        rd_addr_reg <= rd_addr_next;
        value_reg   <= value_next;
        last_reg    <= last_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    `SMOS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= CNT_W'(MAX_ITEMS))
    `SMOS_ASSERT_NEXT(a_full_drop, s_acc && (fill_reg == CNT_W'(MAX_ITEMS)), ovf_reg)
    `SMOS_ASSERT_IMPL(a_pos_bound, state_reg == S_CMP, CNT_W'(pos_reg) <= fill_reg)
    `SMOS_ASSERT_IMPL(a_result_src, $rose(m_tvalid_reg), $past(state_reg == S_MEDD))
endmodule

[rtl/core/smos_ram.sv]
// single write port, single read port ram with registered read data
`timescale 1ns / 1ps
module smos_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end
endmodule

[sim/tb_sorted_median_of_set_unit.sv]
// self-checking testbench for the sorted median unit: directed and random sets
`timescale 1ns / 1ps
module tb_sorted_median_of_set_unit;
    import smos_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_TICKS = 300;
    localparam int PHASE_ITEMS  = 360;

    typedef struct {
        logic [VALUE_W-1:0] value;
        bit                 last;
    } set_item_t;

    typedef struct {
        logic [MED_W-1:0]    median_twice;
        logic [ICNT_W-1:0]   item_count;
        logic [STATUS_W-1:0] status;
    } median_result_t;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EXTREME,
        SPREAD_NEAR_ZERO
    } spread_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    set_item_t      pending_values[$];
    median_result_t expected_medians[$];
    set_item_t      next_item;

    // sorted copy of the current set
    logic signed [VALUE_W-1:0] sorted_vals[MAX_ITEMS];
    int                        kept_count   = 0;
    bit                        dropped_seen = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int idle_ticks     = 0;

    sorted_median_of_set_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic predict_median(input logic signed [VALUE_W-1:0] v, input bit closes);
        int pos;
        int mid;
        median_result_t res;
        if (kept_count >= MAX_ITEMS) begin
            dropped_seen = 1'b1;
        end else begin
            pos = kept_count;
            while (pos > 0 && sorted_vals[pos-1] > v) begin
                sorted_vals[pos] = sorted_vals[pos-1];
                pos--;
            end
            sorted_vals[pos] = v;
            kept_count++;
        end
        if (closes) begin
            if (kept_count == 0) begin
                res.median_twice = '0;
                res.status       = ST_EMPTY;
            end else begin
                mid = kept_count / 2;
                if (kept_count % 2 == 0)
                    res.median_twice = {sorted_vals[mid][VALUE_W-1], sorted_vals[mid]} +
                                       {sorted_vals[mid-1][VALUE_W-1], sorted_vals[mid-1]};
                else
                    res.median_twice = {sorted_vals[mid], 1'b0};
                res.status = dropped_seen ? ST_OVERFLOW : ST_OK;
            end
            res.item_count = kept_count[ICNT_W-1:0];
            expected_medians.push_back(res);
            kept_count   = 0;
            dropped_seen = 1'b0;
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input spread_t spread);
        logic [VALUE_W-1:0] corner[7];
        corner = '{32'h8000_0000, 32'h8000_0001, 32'hffff_ffff, 32'h0000_0000,
                   32'h0000_0001, 32'h7fff_fffe, 32'h7fff_ffff};
        case (spread)
            SPREAD_FULL:    return $urandom;
            SPREAD_NARROW:  return $urandom_range(16) - 8;
            SPREAD_EXTREME: return corner[$urandom_range(6)];
            default:        return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    task automatic add_item(input logic [VALUE_W-1:0] v, input bit closes);
        set_item_t it;
        it.value = v;
        it.last  = closes;
        pending_values.push_back(it);
    endtask

    task automatic add_random_set(input int n);
        spread_t spread;
        spread = spread_t'($urandom_range(3));
        for (int k = 0; k < n; k++)
            add_item(pick_value(spread), k == n - 1);
    endtask

    task automatic wait_drained();
        while (pending_values.size() != 0 || s_tvalid || expected_medians.size() != 0)
            @(negedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_median(s_tdata[VALUE_W-1:0], s_tlast);
            if (!s_tvalid || s_tready) begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_values.pop_front();
                    s_tdata   <= next_item.value;
                    s_tlast   <= next_item.last;
                    s_tvalid  <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        median_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_medians.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
                    error_count++;
                end else begin
                    want = expected_medians.pop_front();
                    if (m_tdata[MED_W-1:0] !== want.median_twice) begin
                        $display("%0t median_twice mismatch: expected %0d actual %0d", $time,
                                 $signed(want.median_twice), $signed(m_tdata[MED_W-1:0]));
                        error_count++;
                    end
                    if (m_tdata[MED_W +: ICNT_W] !== want.item_count) begin
                        $display("%0t item_count mismatch: expected %0d actual %0d", $time,
                                 want.item_count, m_tdata[MED_W +: ICNT_W]);
                        error_count++;
                    end
                    if (m_tdata[MED_W+ICNT_W +: STATUS_W] !== want.status) begin
                        $display("%0t status mismatch: expected %0d actual %0d", $time,
                                 want.status, m_tdata[MED_W+ICNT_W +: STATUS_W]);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_ticks <= 0;
        end else if (idle_ticks >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_ticks <= idle_ticks + 1;
        end
    end

    initial begin
        int send_pct[4];
        int recv_pct[4];
        int queued;
        int n;
        send_pct = '{0, 60, 0, 13};
        recv_pct = '{0, 0, 60, 13};

        // extremes, alone and in pairs
        add_item(32'h7fff_ffff, 1'b1);
        add_item(32'h8000_0000, 1'b1);
        add_item(32'h8000_0000, 1'b0);
        add_item(32'h7fff_ffff, 1'b1);
        add_item(32'h7fff_ffff, 1'b0);
        add_item(32'h7fff_ffff, 1'b1);
        add_item(32'h8000_0000, 1'b0);
        add_item(32'h8000_0000, 1'b1);
        // descending: longest walk down the store
        for (int k = 5; k >= 1; k--)
            add_item(k, k == 1);
        // ascending, even count
        for (int k = -1; k <= 2; k++)
            add_item(k, k == 2);
        // equal values
        for (int k = 0; k < 3; k++)
            add_item(7, k == 2);
        add_item(32'h0000_0000, 1'b0);
        add_item(32'hffff_ffff, 1'b1);
        // store filled exactly, then past capacity
        add_random_set(MAX_ITEMS);
        add_random_set(MAX_ITEMS + 6);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            @(negedge aclk);
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            queued = 0;
            while (queued < PHASE_ITEMS) begin
                if ($urandom_range(99) < 5)
                    n = $urandom_range(MAX_ITEMS + 8, MAX_ITEMS - 8);
                else
                    n = $urandom_range(12, 1);
                add_random_set(n);
                queued += n;
            end
            wait_drained();
        end

        repeat (SETTLE_TICKS) @(posedge aclk);
        if (error_count == 0 && expected_medians.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[sorted_median_of_set_unit.f]
+incdir+rtl/core
rtl/core/smos_pkg.sv
rtl/core/smos_ram.sv
rtl/core/sorted_median_of_set_unit.sv
sim/tb_sorted_median_of_set_unit.sv
